// File: rtl/stereo_frame_fifo_core_assert.svh
// Assertion macros shared by the stereo frame FIFO modules.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef STEREO_FRAME_FIFO_CORE_ASSERT_SVH
`define STEREO_FRAME_FIFO_CORE_ASSERT_SVH

// Same-cycle implication.
`define SFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sff_pkg.sv
`timescale 1ns / 1ps

package sff_pkg;

  localparam int unsigned DEF_CAPACITY = 4096;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned RATE_W       = 19;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned FRAME_W      = 2 * SAMPLE_W;
  localparam int unsigned IN_TDATA_W   = 56;
  localparam int unsigned IN_TUSER_W   = 2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ARG    = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load_samples;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_stat_t;

endpackage

// File: rtl/sff_ram.sv
`timescale 1ns / 1ps

module sff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sff_ctrl.sv
`timescale 1ns / 1ps
`include "stereo_frame_fifo_core_assert.svh"

module sff_ctrl
  import sff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free          = !out_valid_r || out_tready;
    in_tready         = 1'b0;
    cmd.accept        = 1'b0;
    cmd.load_samples  = 1'b0;
    state_nxt         = state_r;
    // drop the result beat once taken
    out_valid_nxt     = out_valid_r && !out_tready;
    case (state_r)
      CS_IDLE: begin
        in_tready  = out_free;
        cmd.accept = in_tvalid && out_free;
        if (cmd.accept) begin
          if (stat.need_read) begin
            state_nxt = CS_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      CS_READ: begin
        // memory data is back; the output slot was freed at accept
        cmd.load_samples = 1'b1;
        out_valid_nxt    = 1'b1;
        state_nxt        = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  `SFF_ASSERT_NEXT(a_pop_goes_read, cmd.accept && stat.need_read, state_r == CS_READ,
    "pop with stored frame did not enter read state")
  `SFF_ASSERT_NEXT(a_read_one_cycle, state_r == CS_READ, (state_r == CS_IDLE) && out_valid_r,
    "read state did not present its result beat")

endmodule

// File: rtl/sff_dp.sv
`timescale 1ns / 1ps
`include "stereo_frame_fifo_core_assert.svh"

module sff_dp
  import sff_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = DEF_CAPACITY,
  localparam int unsigned PTR_W  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1,
  localparam int unsigned FILL_W = $clog2(FRAME_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  op_t                 op,
  input  logic [SAMPLE_W-1:0] left_in,
  input  logic [SAMPLE_W-1:0] right_in,
  input  logic [RATE_W-1:0]   rate_in,
  output status_t             status,
  output logic                frame_done,
  output logic [SAMPLE_W-1:0] left_out,
  output logic [SAMPLE_W-1:0] right_out,
  output logic                is_active,
  output logic [RATE_W-1:0]   rate_now,
  output logic [FILL_W-1:0]   fill_level,
  output logic [CNT_W-1:0]    underruns,
  output logic [CNT_W-1:0]    overflows
);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FRAME_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FRAME_DEPTH);

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  under_r, under_nxt;
  logic [CNT_W-1:0]  over_r, over_nxt;
  logic              active_r, active_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  status_t             o_status_r, st_nxt;
  logic                o_done_r, done_nxt;
  logic [SAMPLE_W-1:0] o_left_r, o_right_r;
  logic                o_active_r;
  logic [RATE_W-1:0]   o_rate_r;
  logic [FILL_W-1:0]   o_fill_r;
  logic [CNT_W-1:0]    o_under_r, o_over_r;

  logic               push_ok;
  logic               pop_ok;
  logic [FRAME_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    under_nxt  = under_r;
    over_nxt   = over_r;
    active_nxt = active_r;
    rate_nxt   = rate_r;
    st_nxt     = ST_OK;
    done_nxt   = 1'b0;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    case (op)
      OP_PUSH: begin
        if (!active_r) begin
          st_nxt = ST_NOT_ACTIVE;
        end else if (fill_r == FILL_MAX) begin
          st_nxt   = ST_FULL;
          over_nxt = over_r + 1'b1;
        end else begin
          push_ok    = 1'b1;
          wr_ptr_nxt = next_slot(wr_ptr_r);
          fill_nxt   = fill_r + 1'b1;
          done_nxt   = 1'b1;
        end
      end
      OP_POP: begin
        if (!active_r) begin
          st_nxt = ST_NOT_ACTIVE;
        end else if (fill_r == '0) begin
          under_nxt = under_r + 1'b1;
        end else begin
          pop_ok     = 1'b1;
          rd_ptr_nxt = next_slot(rd_ptr_r);
          fill_nxt   = fill_r - 1'b1;
          done_nxt   = 1'b1;
        end
      end
      OP_START: begin
        if (rate_in == '0) begin
          st_nxt = ST_BAD_ARG;
        end else begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          fill_nxt   = '0;
          under_nxt  = '0;
          over_nxt   = '0;
          rate_nxt   = rate_in;
          active_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        fill_nxt   = '0;
        under_nxt  = '0;
        over_nxt   = '0;
        rate_nxt   = '0;
        active_nxt = 1'b0;
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
    stat.need_read = pop_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      under_r  <= '0;
      over_r   <= '0;
      active_r <= 1'b0;
      rate_r   <= '0;
    end else if (cmd.accept) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      under_r  <= under_nxt;
      over_r   <= over_nxt;
      active_r <= active_nxt;
      rate_r   <= rate_nxt;
    end
  end

  // result beat: status fields at accept, samples from memory in the next cycle, in the read state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      o_status_r <= st_nxt;
      o_done_r   <= done_nxt;
      o_left_r   <= '0;
      o_right_r  <= '0;
      o_active_r <= active_nxt;
      o_rate_r   <= rate_nxt;
      o_fill_r   <= fill_nxt;
      o_under_r  <= under_nxt;
      o_over_r   <= over_nxt;
    end else if (cmd.load_samples) begin
      o_left_r  <= ram_rdata[SAMPLE_W-1:0];
      o_right_r <= ram_rdata[FRAME_W-1:SAMPLE_W];
    end
  end

  sff_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && push_ok),
    .waddr (wr_ptr_r),
    .wdata ({right_in, left_in}),
    .re    (cmd.accept && pop_ok),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign status     = o_status_r;
  assign frame_done = o_done_r;
  assign left_out   = o_left_r;
  assign right_out  = o_right_r;
  assign is_active  = o_active_r;
  assign rate_now   = o_rate_r;
  assign fill_level = o_fill_r;
  assign underruns  = o_under_r;
  assign overflows  = o_over_r;

  `SFF_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FILL_MAX,
    "fill count exceeds capacity")
  `SFF_ASSERT_NOW(a_empty_ptrs, fill_r == '0, rd_ptr_r == wr_ptr_r,
    "empty buffer with read and write pointers apart")

endmodule

// File: rtl/stereo_frame_fifo_core.sv
`timescale 1ns / 1ps
// Stereo frame FIFO: a ring buffer of FRAME_DEPTH 32-bit stereo frames driven by one
// operation per input beat (push, pop, start with a rate, stop), each answered by exactly
// one result beat carrying the status word, the popped samples and the buffer counters as
// they stand after the operation. Push, start, stop and pops that find the buffer empty or
// the stream inactive go straight from accept to their result beat; a pop that returns a
// stored frame passes through a read state for the registered read of the frame memory, during
// which the input is held off. A result beat waiting in the output register holds off the
// next operation until it is taken; the next operation may enter in the cycle the waiting
// beat leaves. The frame memory needs no clearing after reset or start, since a pop reads
// only frames written since the last clear.
module stereo_frame_fifo_core
  import sff_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = DEF_CAPACITY,
  localparam int unsigned FILL_W     = $clog2(FRAME_DEPTH + 1),
  localparam int unsigned OUT_BITS   = 4 + 2 * SAMPLE_W + RATE_W + FILL_W + 2 * CNT_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // left_in[15:0], right_in[31:16], rate_in[50:32], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], frame_done[2], left_out[18:3], right_out[34:19], is_active[35],
  // rate_now[54:36], fill_level, underruns, overflows, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t           cmd;
  dp_stat_t            stat;
  status_t             status;
  logic                frame_done;
  logic [SAMPLE_W-1:0] left_out;
  logic [SAMPLE_W-1:0] right_out;
  logic                is_active;
  logic [RATE_W-1:0]   rate_now;
  logic [FILL_W-1:0]   fill_level;
  logic [CNT_W-1:0]    underruns;
  logic [CNT_W-1:0]    overflows;

  sff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sff_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op_t'(in_tuser[1:0])),
    .left_in    (in_tdata[SAMPLE_W-1:0]),
    .right_in   (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .rate_in    (in_tdata[2*SAMPLE_W+RATE_W-1:2*SAMPLE_W]),
    .status     (status),
    .frame_done (frame_done),
    .left_out   (left_out),
    .right_out  (right_out),
    .is_active  (is_active),
    .rate_now   (rate_now),
    .fill_level (fill_level),
    .underruns  (underruns),
    .overflows  (overflows)
  );

  assign out_tdata = OUT_TDATA_W'({overflows, underruns, fill_level, rate_now, is_active,
                                   right_out, left_out, frame_done, status});

endmodule
